// File: sv/windowed_edge_event_log_unit_assert.svh
// Assertion macros for the windowed edge event log unit.
// Used by the top level only; needs a clock and an active-low reset.
`ifndef WINDOWED_EDGE_EVENT_LOG_UNIT_ASSERT_SVH
`define WINDOWED_EDGE_EVENT_LOG_UNIT_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define WEEL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define WEEL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/weel_pkg.sv
// Shared types and constants of the windowed edge event log unit.
// No dependencies.
`timescale 1ns / 1ps

package weel_pkg;

    localparam int TIME_W      = 32;
    localparam int SAMPLE_W    = 16;
    localparam int CHAN_W      = 3;
    localparam int MAX_RESULTS = 32;

    localparam logic [TIME_W-1:0] DEFAULT_WINDOW = 32'd10;

    typedef struct packed {
        logic [TIME_W-1:0] ev_time;
        logic              ev_level;
    } t_entry;

endpackage

// File: sv/weel_log_ram.sv
// Event log store: one write port, one read port, registered read data.
// Depends on weel_pkg for the entry type.
`timescale 1ns / 1ps

module weel_log_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  weel_pkg::t_entry  i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output weel_pkg::t_entry  o_rdata
);
    import weel_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/windowed_edge_event_log_unit.sv
// Top level of the windowed edge event log unit: sequencer and per-channel pointers.
// Depends on weel_pkg, weel_log_ram and windowed_edge_event_log_unit_assert.svh.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; busy then stays high
// until the last event of that request has left. Each request runs an update
// step, an extra step to fetch the newest time when no edge was logged and the
// window is on, a compare step for each entry checked against the window (each
// evicted entry, plus one for the entry that stays unless the log shrinks to a
// single entry; none when the window is off or one entry is logged), then a
// readout step for each logged entry (at most 32) and the output register.
// Events come one per cycle on o_strobe, oldest first, and cannot be held off
// by the receiver. A request for a channel number at or above CHANNELS is
// dropped. Entries are read through the single read port of the log memory,
// which needs no clearing pass after reset.
module windowed_edge_event_log_unit #(
    parameter int CHANNELS  = 8,
    parameter int LOG_DEPTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [weel_pkg::TIME_W-1:0]         i_cfg_wdata,
    input  logic                                start,
    output logic                                busy,
    input  logic [weel_pkg::CHAN_W-1:0]         i_channel,
    input  logic signed [weel_pkg::SAMPLE_W-1:0] i_sample,
    input  logic [weel_pkg::TIME_W-1:0]         i_now,
    output logic                                o_strobe,
    output logic [weel_pkg::TIME_W-1:0]         o_event_time,
    output logic                                o_event_level,
    output logic                                o_last,
    output logic                                o_overflow
);
    import weel_pkg::*;

    localparam int MEM_DEPTH = CHANNELS * LOG_DEPTH;
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int SW        = $clog2(LOG_DEPTH);
    localparam int CW        = $clog2(LOG_DEPTH + 1);
    localparam int CIW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_CAP_NEW,
        S_CMP_OLD,
        S_READOUT
    } t_state;

    // wrap an offset from the head within one channel's ring
    function automatic logic [SW-1:0] f_slot(input logic [SW-1:0] head,
                                             input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(off);
        if (sum >= (CW+1)'(LOG_DEPTH)) begin
            sum = sum - (CW+1)'(LOG_DEPTH);
        end
        return SW'(sum);
    endfunction

    t_state            r_state, n_state;
    logic              r_flag  [CHANNELS];
    logic [SW-1:0]     r_head  [CHANNELS];
    logic [CW-1:0]     r_count [CHANNELS];
    logic [TIME_W-1:0] r_window;
    logic [CIW-1:0]    r_ch;
    logic [AW-1:0]     r_base;
    logic              r_high;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_newest, n_newest;
    logic              r_ovf, n_ovf;
    logic [CW-1:0]     r_k, n_k;
    logic              r_pend, n_pend;
    logic              r_pend_last, n_pend_last;

    logic              n_flag;
    logic [SW-1:0]     n_head;
    logic [CW-1:0]     n_count;

    logic              cur_flag;
    logic [SW-1:0]     cur_head;
    logic [CW-1:0]     cur_count;
    logic [CW-1:0]     n_out;
    logic              append;
    logic              full;
    logic              win_on;
    logic              ch_ok;
    logic              accept;
    logic              out_last;
    logic [TIME_W-1:0] span;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    t_entry            mem_wdata;
    logic [AW-1:0]     mem_raddr;
    t_entry            mem_rdata;

    weel_log_ram #(
        .DEPTH (MEM_DEPTH),
        .AW    (AW)
    ) u_log_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign busy      = (r_state != S_IDLE) || r_pend;
    assign ch_ok     = 32'(i_channel) < CHANNELS;
    assign accept    = start && !busy;

    assign cur_flag  = r_flag[r_ch];
    assign cur_head  = r_head[r_ch];
    assign cur_count = r_count[r_ch];
    assign append    = r_high != cur_flag;
    assign full      = cur_count == CW'(LOG_DEPTH);
    assign win_on    = r_window != '0;
    assign span      = r_newest - mem_rdata.ev_time;
    assign n_out     = (32'(cur_count) > MAX_RESULTS) ? CW'(MAX_RESULTS) : cur_count;
    assign out_last  = ((CW+1)'(r_k) + (CW+1)'(1)) == (CW+1)'(n_out);

    always_comb begin
        n_state     = r_state;
        n_flag      = cur_flag;
        n_head      = cur_head;
        n_count     = cur_count;
        n_newest    = r_newest;
        n_ovf       = r_ovf;
        n_k         = r_k;
        n_pend      = 1'b0;
        n_pend_last = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = r_base;
        mem_wdata   = '{ev_time: r_now, ev_level: r_high};
        mem_raddr   = r_base + AW'(cur_head);
        unique case (r_state)
            S_IDLE: begin
                if (accept && ch_ok) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_k = '0;
                if (append) begin
                    // full log: drop oldest, count stays at depth
                    n_head    = full ? f_slot(cur_head, CW'(1)) : cur_head;
                    n_count   = full ? cur_count : cur_count + CW'(1);
                    mem_we    = 1'b1;
                    mem_waddr = r_base + AW'(f_slot(n_head,
                                    full ? CW'(LOG_DEPTH - 1) : cur_count));
                    n_flag    = r_high;
                    n_newest  = r_now;
                    n_ovf     = full;
                    // oldest never aliases the new slot when two or more entries
                    mem_raddr = r_base + AW'(n_head);
                    n_state   = (win_on && n_count > CW'(1)) ? S_CMP_OLD : S_READOUT;
                end else begin
                    n_ovf     = 1'b0;
                    mem_raddr = r_base + AW'(f_slot(cur_head, cur_count - CW'(1)));
                    n_state   = (win_on && cur_count > CW'(1)) ? S_CAP_NEW : S_READOUT;
                end
            end
            S_CAP_NEW: begin
                n_newest  = mem_rdata.ev_time;
                mem_raddr = r_base + AW'(cur_head);
                n_state   = S_CMP_OLD;
            end
            S_CMP_OLD: begin
                if (span > r_window) begin
                    n_head    = f_slot(cur_head, CW'(1));
                    n_count   = cur_count - CW'(1);
                    mem_raddr = r_base + AW'(n_head);
                    n_state   = (n_count > CW'(1)) ? S_CMP_OLD : S_READOUT;
                end else begin
                    n_state = S_READOUT;
                end
            end
            S_READOUT: begin
                if (cur_count == '0) begin
                    n_state = S_IDLE;
                end else begin
                    mem_raddr   = r_base + AW'(f_slot(cur_head, r_k));
                    n_pend      = 1'b1;
                    n_pend_last = out_last;
                    n_k         = r_k + CW'(1);
                    if (out_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= DEFAULT_WINDOW;
            r_ch        <= '0;
            r_pend      <= 1'b0;
            r_pend_last <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_flag[c]  <= 1'b0;
                r_head[c]  <= '0;
                r_count[c] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_pend_last <= n_pend_last;
            if (i_cfg_we) begin
                r_window <= i_cfg_wdata;
            end
            if (accept && ch_ok) begin
                r_ch <= CIW'(i_channel);
            end
            if (r_state != S_IDLE) begin
                r_flag[r_ch]  <= n_flag;
                r_head[r_ch]  <= n_head;
                r_count[r_ch] <= n_count;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept && ch_ok) begin
            r_base <= AW'(32'(i_channel) * LOG_DEPTH);
            r_high <= !i_sample[SAMPLE_W-1] && (i_sample != '0);
            r_now  <= i_now;
        end
        r_newest <= n_newest;
        r_ovf    <= n_ovf;
        r_k      <= n_k;
    end

    assign o_strobe      = r_pend;
    assign o_last        = r_pend_last;
    assign o_overflow    = r_ovf;
    assign o_event_time  = mem_rdata.ev_time;
    assign o_event_level = mem_rdata.ev_level;

`include "windowed_edge_event_log_unit_assert.svh"

    `WEEL_ASSERT_IMP(a_strobe_in_busy, i_clk, i_rst_n, o_strobe, busy, "event outside request")
    `WEEL_ASSERT_IMP(a_last_has_strobe, i_clk, i_rst_n, o_last, o_strobe, "last without event")
    `WEEL_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, cur_count <= CW'(LOG_DEPTH), "log count beyond depth")
    `WEEL_ASSERT_NXT(a_accept_update, i_clk, i_rst_n, accept && ch_ok, r_state == S_UPDATE, "request not taken")

endmodule
